@@ rtl/core/cau_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;
    localparam int WIDTH = 16;
    localparam int FRAC_BITS = 12;
    localparam int PW = 2 * WIDTH + 1;            // sum of two products
    localparam int NW = PW + FRAC_BITS;           // scaled numerator
    localparam int DW = 2 * WIDTH + 1;            // |b|^2
    localparam int QW = NW;                       // quotient magnitude

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_CONJ = 3'd4;

    typedef struct packed {
        logic [2:0] mode;
        logic       dz;
    } t_ctl;

    function automatic logic signed [WIDTH-1:0] sat(input logic signed [NW:0] v,
                                                     output logic clamped);
        logic signed [NW:0] hi;
        logic signed [NW:0] lo;
        begin
            hi = (NW+1)'(signed'({1'b0, {(WIDTH-1){1'b1}}}));
            lo = -hi - (NW+1)'(1);
            clamped = 1'b0;
            if (v > hi) begin
                clamped = 1'b1;
                sat = hi[WIDTH-1:0];
            end else if (v < lo) begin
                clamped = 1'b1;
                sat = lo[WIDTH-1:0];
            end else begin
                sat = v[WIDTH-1:0];
            end
        end
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/complex_arith_unit_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Complex ALU: add, subtract, multiply, divide and conjugate on fixed point.
// The delay is the same for every mode, set by the bit-per-stage divider
// pipeline that all transactions pass through.
// Throughput: one transaction per cycle; busy is always low, and the receiver
// cannot stall, so every result leaves on its strobe without backpressure.
// Reset: synchronous active-low i_rst_n clears every valid bit.
module complex_arith_unit_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [2:0]                        i_mode,
    input  wire logic signed [cau_pkg::WIDTH-1:0]  i_a_real,
    input  wire logic signed [cau_pkg::WIDTH-1:0]  i_a_imag,
    input  wire logic signed [cau_pkg::WIDTH-1:0]  i_b_real,
    input  wire logic signed [cau_pkg::WIDTH-1:0]  i_b_imag,
    output logic                                   o_strobe,
    output logic signed [cau_pkg::WIDTH-1:0]       o_res_real,
    output logic signed [cau_pkg::WIDTH-1:0]       o_res_imag,
    output logic                                   o_saturated,
    output logic                                   o_div_zero
);
    localparam int W = cau_pkg::WIDTH;
    localparam int PW = cau_pkg::PW;
    localparam int NW = cau_pkg::NW;
    localparam int DW = cau_pkg::DW;
    localparam int L = NW;   // divider depth

    assign busy = 1'b0;

    // Stage 1: the four cross products, the squares of b and the linear results.
    logic r1_v;
    cau_pkg::t_ctl r1_ctl;
    logic signed [2*W-1:0] r1_rr, r1_ii, r1_ri, r1_ir, r1_bb0, r1_bb1;
    logic signed [W:0] r1_lr, r1_li;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else r1_v <= start;
        r1_ctl.mode <= i_mode;
        r1_ctl.dz <= (i_mode == cau_pkg::MODE_DIV) && (i_b_real == '0) && (i_b_imag == '0);
        r1_rr <= i_a_real * i_b_real;
        r1_ii <= i_a_imag * i_b_imag;
        r1_ri <= i_a_real * i_b_imag;
        r1_ir <= i_a_imag * i_b_real;
        r1_bb0 <= i_b_real * i_b_real;
        r1_bb1 <= i_b_imag * i_b_imag;
        unique case (i_mode)
            cau_pkg::MODE_ADD: begin
                r1_lr <= (W+1)'(i_a_real) + (W+1)'(i_b_real);
                r1_li <= (W+1)'(i_a_imag) + (W+1)'(i_b_imag);
            end
            cau_pkg::MODE_SUB: begin
                r1_lr <= (W+1)'(i_a_real) - (W+1)'(i_b_real);
                r1_li <= (W+1)'(i_a_imag) - (W+1)'(i_b_imag);
            end
            default: begin
                r1_lr <= (W+1)'(i_a_real);
                r1_li <= -(W+1)'(i_a_imag);
            end
        endcase
    end

    // Stage 2: sums of products, the denominator, sign and magnitude of the numerators.
    logic r2_v;
    cau_pkg::t_ctl r2_ctl;
    logic signed [PW-1:0] r2_mr, r2_mi;
    logic [NW-1:0] r2_nr, r2_ni;
    logic r2_sr, r2_si;
    logic [cau_pkg::DW-1:0] r2_den;
    logic signed [W:0] r2_lr, r2_li;
    logic signed [PW-1:0] n2_dr, n2_di;
    always_comb begin
        n2_dr = PW'(r1_rr) + PW'(r1_ii);
        n2_di = PW'(r1_ir) - PW'(r1_ri);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else r2_v <= r1_v;
        r2_ctl <= r1_ctl;
        r2_mr <= PW'(r1_rr) - PW'(r1_ii);
        r2_mi <= PW'(r1_ri) + PW'(r1_ir);
        r2_sr <= n2_dr[PW-1];
        r2_si <= n2_di[PW-1];
        r2_nr <= NW'(n2_dr[PW-1] ? -n2_dr : n2_dr) << cau_pkg::FRAC_BITS;
        r2_ni <= NW'(n2_di[PW-1] ? -n2_di : n2_di) << cau_pkg::FRAC_BITS;
        r2_den <= DW'(unsigned'(r1_bb0)) + DW'(unsigned'(r1_bb1));
        r2_lr <= r1_lr;
        r2_li <= r1_li;
    end

    // Divider lanes; a zero divisor gives an unused quotient.
    logic dv_v, dv_v2;
    logic [NW-1:0] q_re, q_im;
    cau_divider u_div_re (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r2_v),
        .i_num(r2_nr), .i_den(r2_den), .o_valid(dv_v), .o_quot(q_re));
    cau_divider u_div_im (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r2_v),
        .i_num(r2_ni), .i_den(r2_den), .o_valid(dv_v2), .o_quot(q_im));

    // Side delay line for everything not divided.
    cau_pkg::t_ctl d_ctl [L+1];
    logic signed [PW-1:0] d_mr [L+1];
    logic signed [PW-1:0] d_mi [L+1];
    logic signed [W:0] d_lr [L+1];
    logic signed [W:0] d_li [L+1];
    logic d_sr [L+1];
    logic d_si [L+1];
    always_comb begin
        d_ctl[0] = r2_ctl; d_mr[0] = r2_mr; d_mi[0] = r2_mi;
        d_lr[0] = r2_lr; d_li[0] = r2_li; d_sr[0] = r2_sr; d_si[0] = r2_si;
    end
    for (genvar k = 0; k < L; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            d_ctl[k+1] <= d_ctl[k]; d_mr[k+1] <= d_mr[k]; d_mi[k+1] <= d_mi[k];
            d_lr[k+1] <= d_lr[k]; d_li[k+1] <= d_li[k];
            d_sr[k+1] <= d_sr[k]; d_si[k+1] <= d_si[k];
        end
    end

    // Stage 3: pick the result by mode.
    logic r3_v;
    cau_pkg::t_ctl r3_ctl;
    logic signed [NW:0] r3_re, r3_im;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else r3_v <= dv_v;
        r3_ctl <= d_ctl[L];
        unique case (d_ctl[L].mode)
            cau_pkg::MODE_ADD, cau_pkg::MODE_SUB, cau_pkg::MODE_CONJ: begin
                r3_re <= (NW+1)'(d_lr[L]);
                r3_im <= (NW+1)'(d_li[L]);
            end
            cau_pkg::MODE_MUL: begin
                r3_re <= (NW+1)'(d_mr[L] >>> cau_pkg::FRAC_BITS);
                r3_im <= (NW+1)'(d_mi[L] >>> cau_pkg::FRAC_BITS);
            end
            cau_pkg::MODE_DIV: begin
                r3_re <= d_sr[L] ? -(NW+1)'(q_re) : (NW+1)'(q_re);
                r3_im <= d_si[L] ? -(NW+1)'(q_im) : (NW+1)'(q_im);
            end
            default: begin
                r3_re <= '0;
                r3_im <= '0;
            end
        endcase
    end

    // Stage 4: saturation into the output register.
    logic c_re, c_im;
    logic signed [W-1:0] n_re, n_im;
    always_comb begin
        n_re = cau_pkg::sat(r3_re, c_re);
        n_im = cau_pkg::sat(r3_im, c_im);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_strobe <= 1'b0;
        else o_strobe <= r3_v;
        if (r3_ctl.dz) begin
            o_res_real <= '0;
            o_res_imag <= '0;
            o_saturated <= 1'b0;
        end else begin
            o_res_real <= n_re;
            o_res_imag <= n_im;
            o_saturated <= c_re | c_im;
        end
        o_div_zero <= r3_ctl.dz;
    end

    // The two divider lanes always run in lockstep.
    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n) dv_v == dv_v2)
        else $error("divider lanes out of step");
    // A divide-by-zero result is zero without a clamp flag.
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_div_zero |-> o_res_real == '0 && o_res_imag == '0 && !o_saturated)
        else $error("divide by zero result not zero");
    // A strobe follows only from valid divider output, through the stage 3 and output registers.
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(dv_v, 2))
        else $error("strobe without transaction");
endmodule
`default_nettype wire

@@ rtl/core/cau_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
module cau_divider (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [cau_pkg::NW-1:0]       i_num,
    input  wire logic [cau_pkg::DW-1:0]       i_den,
    output logic                              o_valid,
    output logic [cau_pkg::QW-1:0]            o_quot
);
    localparam int N = cau_pkg::NW;
    localparam int RW = cau_pkg::DW + 1;

    logic          r_v   [N+1];
    logic [N-1:0]  r_num [N+1];
    logic [RW-1:0] r_rem [N+1];
    logic [cau_pkg::DW-1:0] r_den [N+1];

    always_comb begin
        r_v[0] = i_valid;
        r_num[0] = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        logic [RW-1:0] n_rem;
        logic [RW-1:0] n_trial;
        always_comb begin
            n_rem = {r_rem[s][RW-2:0], r_num[s][N-1]};
            n_trial = n_rem - {1'b0, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_den[s+1] <= r_den[s];
            if (!n_trial[RW-1]) begin
                r_rem[s+1] <= n_trial;
                r_num[s+1] <= {r_num[s][N-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= n_rem;
                r_num[s+1] <= {r_num[s][N-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_quot = r_num[N];
endmodule
`default_nettype wire
